>>> hdl/sphere_frustum_cull_assert.svh
// Assertion macros for the sphere_frustum_cull RTL; sfc_queue includes them.
// Used by files that include this header; expects clk and rst_n in scope.
`ifndef SPHERE_FRUSTUM_CULL_ASSERT_SVH
`define SPHERE_FRUSTUM_CULL_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property holds on every clock outside reset
`define SFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// pre this cycle implies post in the next
`define SFC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SFC_ASSERT(lbl, prop, msg)
`define SFC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> hdl/sfc_pkg.sv
// Package for the sphere frustum culler: widths, item types, helper functions.
// No dependencies; used by every other file in hdl except sfc_out_if and the assertion header.
package sfc_pkg;

  localparam int PLANE_CNT = 6;
  localparam int LANE_W    = 16;
  localparam int VEC_W     = 48;
  localparam int PLANE_W   = 64;
  localparam int ADDR_W    = 6;
  localparam int ADDR_LSB  = 3;
  localparam int IDX_W     = 3;
  localparam int MUL_W     = 32;
  localparam int SQ_W      = 31;
  localparam int G_W       = 33;
  localparam int LEN_W     = 32;
  localparam int ROOT_W    = 16;
  localparam int REM_W     = 18;
  localparam int SQ_STEPS  = 16;
  localparam int RAD_W     = 32;
  localparam int PROD_W    = 49;
  localparam int BIAS_W    = 48;
  localparam int SUM_W     = 53;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;
  localparam int T_SHIFT   = 8;   // translation Q8.8 -> Q.16
  localparam int R_SHIFT   = 14;  // radius Q.16 -> Q.30
  localparam int D_SHIFT   = 22;  // plane distance Q8.8 -> Q.30
  localparam int D_LANE    = 3;

  typedef logic [PLANE_CNT-1:0][PLANE_W-1:0] plane_arr_t;

  // world centre and scaled radius handed from front to back
  typedef struct packed {
    logic signed [G_W-1:0] gx;
    logic signed [G_W-1:0] gy;
    logic signed [G_W-1:0] gz;
    logic [RAD_W-1:0]      rad;
  } sfc_item_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_state_t;

  // signed 16-bit lane k of a packed word
  function automatic logic signed [LANE_W-1:0] lane16(input logic [PLANE_W-1:0] v,
                                                      input int unsigned k);
    return $signed(v[LANE_W*k +: LANE_W]);
  endfunction

  // one digit of the restoring integer square root
  function automatic sq_state_t sqrt_step(input sq_state_t s, input logic [1:0] pair);
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    sq_state_t        o;
    acc   = {s.rem, pair};
    trial = {{(REM_W - ROOT_W){1'b0}}, s.root, 2'b01};
    if (acc >= trial) begin
      o.rem  = REM_W'(acc - trial);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = acc[REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> hdl/sfc_in_if.sv
// Input channel interface: one object per transaction.
// Depends on sfc_pkg for field widths.
interface sfc_in_if import sfc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VEC_W-1:0] center_xyz;
  logic [LANE_W-1:0] radius;
  logic [VEC_W-1:0] column_zero;
  logic [VEC_W-1:0] column_one;
  logic [VEC_W-1:0] column_two;
  logic [VEC_W-1:0] column_three;

  modport source (output valid, center_xyz, radius, column_zero, column_one,
                  column_two, column_three, input ready);
  modport sink   (input valid, center_xyz, radius, column_zero, column_one,
                  column_two, column_three, output ready);
endinterface

>>> hdl/sfc_out_if.sv
// Result channel interface: one visibility flag per transaction.
// No dependencies.
interface sfc_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

>>> hdl/sfc_regs.sv
// APB-style register file holding the six frustum planes.
// Depends on sfc_pkg.
module sfc_regs import sfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PLANE_W-1:0] pwdata,
  output logic [PLANE_W-1:0] prdata,
  output logic               pready,
  output plane_arr_t         planes
);

  plane_arr_t       planes_r;
  logic [IDX_W-1:0] idx;
  logic             idx_ok;

  assign idx    = paddr[ADDR_W-1:ADDR_LSB];
  assign idx_ok = idx < IDX_W'(PLANE_CNT);
  assign pready = 1'b1;
  assign planes = planes_r;

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r <= '0;
    end else if (psel && penable && pwrite && idx_ok) begin
      planes_r[idx] <= pwdata;
    end
  end

  // read mux, unknown slots read zero
  always_comb begin
    prdata = '0;
    if (idx_ok) prdata = planes_r[idx];
  end

endmodule

>>> hdl/sfc_front.sv
// Front end: world-space centre, column lengths, pipelined square root, scaled radius.
// Depends on sfc_pkg and sfc_in_if.
module sfc_front import sfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sfc_in_if.sink    in_obj,
  input  logic      q_full,
  output logic      push,
  output sfc_item_t item
);

  logic adv;

  logic [VEC_W-1:0] cols [3];

  // stage 1: products
  logic                     s1_v_r;
  logic signed [MUL_W-1:0]  s1_prod_r [3][3];
  logic signed [LANE_W-1:0] s1_tr_r [3];
  logic [SQ_W-1:0]          s1_sq_r [3][3];
  logic [LANE_W-1:0]        s1_rad_r;

  // stage 2: sums
  logic                   s2_v_r;
  logic signed [G_W-1:0]  s2_g_r [3];
  logic [LEN_W-1:0]       s2_len_r [3];
  logic [LANE_W-1:0]      s2_rad_r;
  logic signed [G_W-1:0]  g_nxt [3];
  logic [LEN_W-1:0]       len_nxt [3];
  logic [LEN_W-1:0]       best_nxt;

  // square root stages, entry 0 holds the largest squared length
  logic                  sq_v_r   [SQ_STEPS+1];
  sq_state_t             sq_st_r  [SQ_STEPS+1];
  logic [LEN_W-1:0]      sq_val_r [SQ_STEPS+1];
  logic signed [G_W-1:0] sq_g_r   [SQ_STEPS+1][3];
  logic [LANE_W-1:0]     sq_rad_r [SQ_STEPS+1];

  // final stage: scaled radius
  logic      s4_v_r;
  sfc_item_t s4_item_r;

  assign cols[0] = in_obj.column_zero;
  assign cols[1] = in_obj.column_one;
  assign cols[2] = in_obj.column_two;

  // the whole pipe moves unless the tail is blocked by a full queue
  assign adv          = !s4_v_r || !q_full;
  assign in_obj.ready = adv;
  assign push         = s4_v_r && !q_full;
  assign item         = s4_item_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      sq_v_r[0] <= 1'b0;
      s4_v_r    <= 1'b0;
    end else if (adv) begin
      s1_v_r    <= in_obj.valid;
      s2_v_r    <= s1_v_r;
      sq_v_r[0] <= s2_v_r;
      s4_v_r    <= sq_v_r[SQ_STEPS];
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        s1_tr_r[r] <= lane16(PLANE_W'(in_obj.column_three), r);
        for (int k = 0; k < 3; k++) begin
          s1_prod_r[r][k] <= lane16(PLANE_W'(cols[k]), r) *
                             lane16(PLANE_W'(in_obj.center_xyz), k);
          s1_sq_r[k][r]   <= SQ_W'(lane16(PLANE_W'(cols[k]), r) *
                                   lane16(PLANE_W'(cols[k]), r));
        end
      end
      s1_rad_r <= in_obj.radius;
    end
  end

  // stage 2 sums and stage 3 maximum
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      g_nxt[r] = (G_W'(s1_tr_r[r]) <<< T_SHIFT) + G_W'(s1_prod_r[r][0]) +
                 G_W'(s1_prod_r[r][1]) + G_W'(s1_prod_r[r][2]);
      len_nxt[r] = LEN_W'(s1_sq_r[r][0]) + LEN_W'(s1_sq_r[r][1]) +
                   LEN_W'(s1_sq_r[r][2]);
    end
    best_nxt = s2_len_r[0];
    if (s2_len_r[1] > best_nxt) best_nxt = s2_len_r[1];
    if (s2_len_r[2] > best_nxt) best_nxt = s2_len_r[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_g_r      <= g_nxt;
      s2_len_r    <= len_nxt;
      s2_rad_r    <= s1_rad_r;
      sq_st_r[0]  <= '0;
      sq_val_r[0] <= best_nxt;
      sq_g_r[0]   <= s2_g_r;
      sq_rad_r[0] <= s2_rad_r;
    end
  end

  // one root digit per stage
  for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else if (adv) begin
        sq_v_r[j] <= sq_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_st_r[j]  <= sqrt_step(sq_st_r[j-1], sq_val_r[j-1][LEN_W-1 -: 2]);
        sq_val_r[j] <= sq_val_r[j-1] << 2;
        sq_g_r[j]   <= sq_g_r[j-1];
        sq_rad_r[j] <= sq_rad_r[j-1];
      end
    end
  end

  // radius times scale
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_item_r.gx  <= sq_g_r[SQ_STEPS][0];
      s4_item_r.gy  <= sq_g_r[SQ_STEPS][1];
      s4_item_r.gz  <= sq_g_r[SQ_STEPS][2];
      s4_item_r.rad <= RAD_W'(sq_rad_r[SQ_STEPS]) * RAD_W'(sq_st_r[SQ_STEPS].root);
    end
  end

endmodule

>>> hdl/sfc_queue.sv
// Short queue between front and back ends.
// Depends on sfc_pkg and the assertion header.
`include "sphere_frustum_cull_assert.svh"
module sfc_queue import sfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sfc_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output sfc_item_t q_item
);

  sfc_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r;
  logic [Q_PTR_W-1:0] rd_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign full    = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_item  = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  `SFC_ASSERT(a_q_bound, cnt_r <= Q_CNT_W'(Q_DEPTH), "queue count above depth")
  `SFC_ASSERT(a_q_no_ovf, push |-> !full, "push into full queue")
  `SFC_ASSERT(a_q_no_unf, pop |-> q_valid, "pop from empty queue")
  `SFC_ASSERT_NEXT(a_q_fill, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count missed push")

endmodule

>>> hdl/sfc_back.sv
// Back end: six plane tests on the world sphere and the result register.
// Depends on sfc_pkg and sfc_out_if.
module sfc_back import sfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  plane_arr_t planes,
  input  logic       q_valid,
  input  sfc_item_t  q_item,
  output logic       pop,
  sfc_out_if.source  out_res
);

  logic adv;

  logic                     a_v_r;
  logic signed [PROD_W-1:0] a_prod_r [PLANE_CNT][3];
  logic signed [BIAS_W-1:0] a_bias_r [PLANE_CNT];

  logic signed [G_W-1:0]    g [3];
  logic signed [SUM_W-1:0]  sum [PLANE_CNT];
  logic                     vis;

  logic out_v_r;
  logic out_vis_r;

  assign adv             = !out_v_r || out_res.ready;
  assign pop             = adv && q_valid;
  assign out_res.valid   = out_v_r;
  assign out_res.visible = out_vis_r;

  assign g[0] = q_item.gx;
  assign g[1] = q_item.gy;
  assign g[2] = q_item.gz;

  // stage A: normal times centre, radius minus distance
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < PLANE_CNT; p++) begin
        for (int k = 0; k < 3; k++) begin
          a_prod_r[p][k] <= PROD_W'(lane16(planes[p], k)) * PROD_W'(g[k]);
        end
        a_bias_r[p] <= $signed({2'b00, q_item.rad, {R_SHIFT{1'b0}}}) -
                       (BIAS_W'(lane16(planes[p], D_LANE)) <<< D_SHIFT);
      end
    end
  end

  // stage B: every signed distance must exceed minus the radius
  always_comb begin
    vis = 1'b1;
    for (int p = 0; p < PLANE_CNT; p++) begin
      sum[p] = SUM_W'(a_prod_r[p][0]) + SUM_W'(a_prod_r[p][1]) +
               SUM_W'(a_prod_r[p][2]) + SUM_W'(a_bias_r[p]);
      if (sum[p][SUM_W-1] || sum[p] == '0) vis = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r   <= q_valid;
      out_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_vis_r <= vis;
  end

endmodule

>>> hdl/sphere_frustum_cull.sv
// Top level of the bounding-sphere frustum culler.
// Depends on sfc_pkg, sfc_in_if, sfc_out_if, sfc_regs, sfc_front, sfc_queue, sfc_back.
//
//  channel   | kind            | width  | per transaction
//  ----------+-----------------+--------+------------------------------------
//  in_obj    | valid/ready in  | 256 b  | one object: centre, radius, columns
//  out_res   | valid/ready out | 1 b    | visible flag
//  APB       | config write/rd | 64 b   | one plane, byte address 8*index
//
// One object is taken per cycle unless the front stalls; an input transaction passes
// the 20 front stages, set mostly by the 16-step square root, then the queue and one
// plane-product stage whose sums feed the output register.
// Reset is synchronous active low; planes reset to zero, no clearing pass.
// The front stalls only when the 4-entry queue is full; the back stalls
// only while its result waits on out_res.ready.
module sphere_frustum_cull import sfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  sfc_in_if.sink             in_obj,
  sfc_out_if.source          out_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PLANE_W-1:0] pwdata,
  output logic [PLANE_W-1:0] prdata,
  output logic               pready
);

  plane_arr_t planes;
  logic       push;
  sfc_item_t  push_item;
  logic       q_full;
  logic       pop;
  logic       q_valid;
  sfc_item_t  q_item;

  sfc_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .planes
  );

  sfc_front u_front (
    .clk, .rst_n, .in_obj, .q_full, .push, .item(push_item)
  );

  sfc_queue u_queue (
    .clk, .rst_n, .push, .push_item, .full(q_full), .pop, .q_valid, .q_item
  );

  sfc_back u_back (
    .clk, .rst_n, .planes, .q_valid, .q_item, .pop, .out_res
  );

endmodule

>>> dv/sfc_cull_checker.sv
// Scoreboard for the sphere frustum culler: tracks plane writes, predicts visibility.
// Depends on sfc_pkg, sfc_in_if and sfc_out_if; instantiated by tb_sphere_frustum_cull.
module sfc_cull_checker import sfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  sfc_in_if                  in_obj,
  sfc_out_if                 out_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PLANE_W-1:0] pwdata,
  output int                 errors,
  output int                 pending,
  output int                 n_results,
  output int                 n_visible
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PLANE_W-1:0] plane_copy [PLANE_CNT];
  bit                 visible_q [$];

  function automatic longint lane_val(input logic [PLANE_W-1:0] v, input int k);
    return longint'($signed(v[LANE_W*k +: LANE_W]));
  endfunction

  // floor square root, bit by bit
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic bit cull_visible(input logic [VEC_W-1:0] ctr, input logic [15:0] rad,
                                      input logic [VEC_W-1:0] c0, input logic [VEC_W-1:0] c1,
                                      input logic [VEC_W-1:0] c2, input logic [VEC_W-1:0] c3);
    longint            g [3];
    logic [VEC_W-1:0]  col [3];
    longint unsigned   best;
    longint unsigned   len_sq;
    longint            rad_q30;
    longint            dot;
    bit                vis;
    col[0] = c0; col[1] = c1; col[2] = c2;
    // world-space centre in Q.16
    for (int r = 0; r < 3; r++) begin
      g[r] = lane_val(c3, r) * 256;
      for (int k = 0; k < 3; k++) g[r] += lane_val(col[k], r) * lane_val(ctr, k);
    end
    // scale = sqrt of the longest squared column
    best = 0;
    for (int k = 0; k < 3; k++) begin
      len_sq = 0;
      for (int r = 0; r < 3; r++) len_sq += longint'(lane_val(col[k], r) * lane_val(col[k], r));
      if (len_sq > best) best = len_sq;
    end
    rad_q30 = longint'(rad) * longint'(floor_root(best)) * 16384;
    vis = 1'b1;
    for (int p = 0; p < PLANE_CNT; p++) begin
      dot = -lane_val(plane_copy[p], 3) * 4194304;
      for (int k = 0; k < 3; k++) dot += lane_val(plane_copy[p], k) * g[k];
      if (!(dot + rad_q30 > 0)) vis = 1'b0;
    end
    return vis;
  endfunction

  assign pending = visible_q.size();

  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      for (int p = 0; p < PLANE_CNT; p++) plane_copy[p] = '0;
      visible_q.delete();
      errors = 0;
      n_results = 0;
      n_visible = 0;
    end else begin
      // input transaction: predict against planes in force now
      if (in_obj.valid && in_obj.ready)
        visible_q = {visible_q, cull_visible(in_obj.center_xyz, in_obj.radius,
                                             in_obj.column_zero, in_obj.column_one,
                                             in_obj.column_two, in_obj.column_three)};
      // result transaction
      if (out_res.valid && out_res.ready) begin
        n_results++;
        if (out_res.visible === 1'b1) n_visible++;
        if (visible_q.size() == 0) begin
          $error("result with no object outstanding: visible=%0b", out_res.visible);
          errors++;
        end else begin
          want = visible_q.pop_front();
          if (out_res.visible !== want) begin
            $error("visible mismatch: expected %0b actual %0b", want, out_res.visible);
            errors++;
          end
        end
      end
      // plane write; indices past the last plane are dropped
      if (psel && penable && pwrite && pready && (paddr >> ADDR_LSB) < PLANE_CNT)
        plane_copy[paddr >> ADDR_LSB] = pwdata;
    end
  end
endmodule

>>> dv/tb_sphere_frustum_cull.sv
// Testbench top for sphere_frustum_cull: clock, reset, object stimulus, plane setup, verdict.
// Depends on sfc_pkg, sfc_in_if, sfc_out_if, the RTL top and sfc_cull_checker.
module tb_sphere_frustum_cull;
  import sfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYC  = 32;
  localparam int STALL_LIM  = 3000;
  localparam int HOLD_START = 1500;
  localparam int HOLD_LEN   = 300;

  logic               clk;
  logic               rst_n;
  logic               psel, penable, pwrite, pready;
  logic [ADDR_W-1:0]  paddr;
  logic [PLANE_W-1:0] pwdata, prdata;
  int                 errors, pending, n_results, n_visible;
  int                 n_sent, n_cfg, idle_cyc;
  bit                 src_busy_only;

  sfc_in_if  in_obj ();
  sfc_out_if out_res ();

  sphere_frustum_cull uut (
    .clk(clk), .rst_n(rst_n), .in_obj(in_obj), .out_res(out_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sfc_cull_checker chk (
    .clk(clk), .rst_n(rst_n), .in_obj(in_obj), .out_res(out_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending),
    .n_results(n_results), .n_visible(n_visible)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: cycles with no transaction of any kind
  always @(posedge clk) begin
    if ((in_obj.valid && in_obj.ready) || (out_res.valid && out_res.ready) || psel)
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc > STALL_LIM) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, one stretch always ready
  initial begin
    int cyc;
    out_res.ready = 1'b0;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
        out_res.ready = 1'b0;
      else if (cyc >= 400 && cyc < 1000)
        out_res.ready = 1'b1;
      else
        out_res.ready = ($urandom_range(99) >= 38);
    end
  end

  function automatic logic [VEC_W-1:0] rand_vec(input bit narrow, input int span);
    logic [VEC_W-1:0] v;
    for (int k = 0; k < 3; k++)
      v[16*k +: 16] = narrow ? 16'($urandom_range(2 * span) - span) : 16'($urandom);
    return v;
  endfunction

  function automatic logic [VEC_W-1:0] pack3(input int x, input int y, input int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // one object transaction; starts and ends at a falling edge
  task automatic send_obj(input logic [VEC_W-1:0] ctr, input logic [15:0] rad,
                          input logic [VEC_W-1:0] c0, input logic [VEC_W-1:0] c1,
                          input logic [VEC_W-1:0] c2, input logic [VEC_W-1:0] c3);
    while (!src_busy_only && $urandom_range(99) < 38) begin
      in_obj.valid = 1'b0;
      @(negedge clk);
    end
    in_obj.valid        = 1'b1;
    in_obj.center_xyz   = ctr;
    in_obj.radius       = rad;
    in_obj.column_zero  = c0;
    in_obj.column_one   = c1;
    in_obj.column_two   = c2;
    in_obj.column_three = c3;
    do @(posedge clk); while (!in_obj.ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    bit narrow;
    logic [VEC_W-1:0] id_like;
    for (int i = 0; i < count; i++) begin
      src_busy_only = (n_sent >= 300 && n_sent < 450);
      narrow = ($urandom_range(99) < 70);
      if (narrow) begin
        // plausible object: transform entries within +-2.0, modest centre and radius
        send_obj(rand_vec(1, 2048), 16'($urandom_range(1024)),
                 rand_vec(1, 512), rand_vec(1, 512), rand_vec(1, 512), rand_vec(1, 8192));
      end else begin
        send_obj(rand_vec(0, 0), 16'($urandom), rand_vec(0, 0), rand_vec(0, 0),
                 rand_vec(0, 0), rand_vec(0, 0));
      end
    end
    src_busy_only = 1'b0;
  endtask

  // APB write: setup then access
  task automatic write_plane(input int idx, input logic [PLANE_W-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'(idx << ADDR_LSB);
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    n_cfg++;
  endtask

  task automatic drain();
    in_obj.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  function automatic logic [PLANE_W-1:0] mk_plane(input int nx, input int ny, input int nz,
                                                  input int d);
    return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  // axis-aligned box frustum: axis normals in Q2.14, distances in Q8.8
  task automatic set_box(input int half);
    write_plane(0, mk_plane(16384, 0, 0, -half));
    write_plane(1, mk_plane(-16384, 0, 0, -half));
    write_plane(2, mk_plane(0, -16384, 0, -half));
    write_plane(3, mk_plane(0, 16384, 0, -half));
    write_plane(4, mk_plane(0, 0, 16384, -half));
    write_plane(5, mk_plane(0, 0, -16384, -half));
  endtask

  initial begin
    logic [VEC_W-1:0] unit_x, unit_y, unit_z, zero_v;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_obj.valid = 1'b0;
    in_obj.center_xyz = '0; in_obj.radius = '0; in_obj.column_zero = '0;
    in_obj.column_one = '0; in_obj.column_two = '0; in_obj.column_three = '0;
    n_sent = 0; n_cfg = 0; idle_cyc = 0; src_busy_only = 1'b0;
    unit_x = pack3(256, 0, 0);
    unit_y = pack3(0, 256, 0);
    unit_z = pack3(0, 0, 256);
    zero_v = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // planes at reset: visible only with a nonzero scaled radius
    send_obj(zero_v, 16'h0000, zero_v, zero_v, zero_v, zero_v);
    send_obj(zero_v, 16'h0100, unit_x, unit_y, unit_z, zero_v);
    send_obj(zero_v, 16'h0000, unit_x, unit_y, unit_z, zero_v);
    send_obj(zero_v, 16'hFFFF, zero_v, zero_v, zero_v, zero_v);
    send_obj(48'h7FFF_7FFF_7FFF, 16'hFFFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
             48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
    send_obj(48'h8000_8000_8000, 16'hFFFF, 48'h8000_8000_8000, 48'h8000_8000_8000,
             48'h8000_8000_8000, 48'h8000_8000_8000);
    send_obj(48'hFFFF_FFFF_FFFF, 16'h0001, 48'hFFFF_FFFF_FFFF, zero_v, zero_v,
             48'hFFFF_FFFF_FFFF);
    send_obj(48'h8000_7FFF_8000, 16'h8000, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000,
             48'h7FFF_7FFF_8000, 48'h8000_8000_7FFF);
    drain();

    // axis box: points on, inside and outside a face; scale and radius cases
    set_box(16 * 256);
    write_plane(6, '1);
    write_plane(7, '1);
    send_obj(pack3(16 * 256, 0, 0), 16'h0000, unit_y, unit_x, unit_z, zero_v);
    send_obj(pack3(16 * 256 - 1, 0, 0), 16'h0000, unit_x, unit_y, unit_z, zero_v);
    send_obj(pack3(17 * 256, 0, 0), 16'h0100, unit_x, unit_y, unit_z, zero_v);
    send_obj(pack3(17 * 256, 0, 0), 16'h0101, unit_x, unit_y, unit_z, zero_v);
    send_obj(zero_v, 16'h0000, zero_v, zero_v, zero_v, pack3(0, 0, -16 * 256));
    send_obj(pack3(4 * 256, 0, 0), 16'h0100, pack3(512, 0, 0), unit_y, unit_z,
             pack3(8 * 256, 0, 0));
    send_obj(zero_v, 16'h0200, zero_v, zero_v, zero_v, pack3(20 * 256, 0, 0));
    send_obj(zero_v, 16'hFFFF, pack3(1, 0, 0), zero_v, zero_v, pack3(-120 * 256, 0, 0));
    send_random(120);
    drain();

    // extreme plane values
    for (int p = 0; p < PLANE_CNT; p++) write_plane(p, mk_plane(32767, 32767, 32767, -32768));
    send_random(110);
    drain();
    for (int p = 0; p < PLANE_CNT; p++) write_plane(p, mk_plane(-32768, -32768, -32768, 32767));
    send_random(110);
    drain();
    for (int p = 0; p < PLANE_CNT; p++) write_plane(p, '1);
    send_random(100);
    drain();

    // random planes, unnormalized normals included
    for (int ph = 0; ph < 3; ph++) begin
      for (int p = 0; p < PLANE_CNT; p++) write_plane(p, {$urandom, $urandom});
      send_random(110);
      drain();
    end

    // narrower and wider boxes
    set_box(4 * 256);
    send_random(140);
    drain();
    set_box(60 * 256);
    send_random(140);
    drain();

    $display("covered %0d objects (%0d results, %0d visible) across %0d plane writes",
             n_sent, n_results, n_visible, n_cfg);
    if (errors == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

>>> files.f
+incdir+hdl
hdl/sfc_pkg.sv
hdl/sfc_in_if.sv
hdl/sfc_out_if.sv
hdl/sfc_regs.sv
hdl/sfc_front.sv
hdl/sfc_queue.sv
hdl/sfc_back.sv
hdl/sphere_frustum_cull.sv
dv/sfc_cull_checker.sv
dv/tb_sphere_frustum_cull.sv
